FILE: design/sks_pkg.sv
// shared types and constants for the sorted key set
// no dependencies; used by sks_cell and sorted_key_set
package sks_pkg;

    localparam int KEY_W        = 32;
    localparam int FUNC_W       = 2;
    localparam int OUT_COUNT_W  = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_COMPARE,
        CMD_INSERT,
        CMD_DELETE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                cmd;
        logic signed [KEY_W-1:0]  probe;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE
    } state_t;

endpackage

FILE: design/sks_cell.sv
// one storage cell of the sorted key row: holds a key, compares it with the
// broadcast probe and shifts keys with its neighbors; uses sks_pkg
module sks_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                               aclk,
    input  sks_pkg::cell_ctl_t                 ctl,
    input  logic [CNT_W-1:0]                   count,
    input  logic                               left_lt,
    input  logic signed [sks_pkg::KEY_W-1:0]   left_key,
    input  logic signed [sks_pkg::KEY_W-1:0]   right_key,
    output logic signed [sks_pkg::KEY_W-1:0]   key_out,
    output logic                               lt_out,
    output logic                               eq_out
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [sks_pkg::KEY_W-1:0] key_reg;
    logic                             lt_reg;
    logic                             eq_reg;
    logic                             occupied;

    assign occupied = (IDX < count);

    always_ff @(posedge aclk) begin
        unique case (ctl.cmd)
            sks_pkg::CMD_COMPARE: begin
                lt_reg <= occupied && (key_reg < ctl.probe);
                eq_reg <= occupied && (key_reg == ctl.probe);
            end
            sks_pkg::CMD_INSERT: begin
                // cells at or past the slot move one place up
                if (!lt_reg) begin
                    key_reg <= left_lt ? ctl.probe : left_key;
                end
            end
            sks_pkg::CMD_DELETE: begin
                // cells from the match onward pull the key from above
                if (!lt_reg) begin
                    key_reg <= right_key;
                end
            end
            sks_pkg::CMD_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

FILE: design/sorted_key_set.sv
// top level of the sorted key set: a row of key cells and the item sequencer
// depends on sks_pkg and sks_cell
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+----------
//  input   | in        | s_func, s_key                                | s_valid / s_ready
//  result  | out       | m_was_present, m_full_refused, m_key_count   | m_valid / m_ready
//
// an item goes through three steps: accept (all cells compare with the key), reduce
// (the row of match flags is or-ed into one present bit), update (cells shift
// and the result register loads); the next item is accepted the cycle after.
// the update step waits while the result register still holds an untaken item.
// synchronous active-low reset empties the set; cell keys are not reset.
module sorted_key_set #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [sks_pkg::FUNC_W-1:0]             s_func,
    input  logic signed [sks_pkg::KEY_W-1:0]       s_key,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_was_present,
    output logic                                   m_full_refused,
    output logic [sks_pkg::OUT_COUNT_W-1:0]        m_key_count
);

    localparam int               CNT_W   = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // sequencer state
    sks_pkg::state_t state_reg, state_next;

    // item held while it is worked on
    logic [sks_pkg::FUNC_W-1:0]        func_reg;
    logic signed [sks_pkg::KEY_W-1:0]  probe_reg;
    logic                              present_reg;

    // number of stored keys
    logic [CNT_W-1:0] count_reg, count_next;

    // result register
    logic                               m_valid_reg;
    logic                               was_present_reg;
    logic                               full_refused_reg;
    logic [sks_pkg::OUT_COUNT_W-1:0]    key_count_reg;

    // row of cells
    logic signed [sks_pkg::KEY_W-1:0] key_vec [CAPACITY];
    logic [CAPACITY-1:0]              lt_vec;
    logic [CAPACITY-1:0]              eq_vec;
    sks_pkg::cell_ctl_t               ctl;

    logic in_fire;
    logic out_free;
    logic update_fire;
    logic is_full;
    logic do_insert;
    logic do_delete;
    logic refuse;

    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign update_fire = (state_reg == sks_pkg::ST_UPDATE) && out_free;
    assign is_full     = (count_reg == CAP_CNT);

    assign do_insert = (func_reg == sks_pkg::FUNC_INSERT) && !present_reg && !is_full;
    assign do_delete = (func_reg == sks_pkg::FUNC_DELETE) && present_reg;
    assign refuse    = (func_reg == sks_pkg::FUNC_INSERT) && !present_reg && is_full;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sks_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = sks_pkg::ST_REDUCE;
                end
            end
            sks_pkg::ST_REDUCE: begin
                state_next = sks_pkg::ST_UPDATE;
            end
            sks_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = sks_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sks_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: input ready and the command broadcast to the cells
    always_comb begin
        s_ready   = 1'b0;
        ctl.cmd   = sks_pkg::CMD_HOLD;
        ctl.probe = probe_reg;
        unique case (state_reg)
            sks_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                // compare straight against the incoming key
                ctl.probe = s_key;
                if (s_valid) begin
                    ctl.cmd = sks_pkg::CMD_COMPARE;
                end
            end
            sks_pkg::ST_REDUCE: begin
            end
            sks_pkg::ST_UPDATE: begin
                if (out_free && do_insert) begin
                    ctl.cmd = sks_pkg::CMD_INSERT;
                end else if (out_free && do_delete) begin
                    ctl.cmd = sks_pkg::CMD_DELETE;
                end
            end
            default: begin
            end
        endcase
    end

    // count after the update
    always_comb begin
        count_next = count_reg;
        if (update_fire && do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (update_fire && do_delete) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sks_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (update_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg  <= s_func;
            probe_reg <= s_key;
        end
        if (state_reg == sks_pkg::ST_REDUCE) begin
            // keys are distinct, so at most one cell matches
            present_reg <= |eq_vec;
        end
        if (update_fire) begin
            was_present_reg  <= present_reg;
            full_refused_reg <= refuse;
            key_count_reg    <= sks_pkg::OUT_COUNT_W'(count_next);
        end
    end

    // the cell row; cell 0 sees everything to its left as smaller
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                             left_lt;
        logic signed [sks_pkg::KEY_W-1:0] left_key;
        logic signed [sks_pkg::KEY_W-1:0] right_key;

        if (i == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_key = '0;
        end else begin : g_inner
            assign left_lt  = lt_vec[i-1];
            assign left_key = key_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_upper
            assign right_key = key_vec[i+1];
        end

        sks_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count_reg),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .right_key (right_key),
            .key_out   (key_vec[i]),
            .lt_out    (lt_vec[i]),
            .eq_out    (eq_vec[i])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_was_present  = was_present_reg;
    assign m_full_refused = full_refused_reg;
    assign m_key_count    = key_count_reg;

`ifndef NO_ASSERTIONS
    // the count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("key count above capacity");

    // sorted distinct keys give at most one match in the row
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sks_pkg::ST_REDUCE) |-> $onehot0(eq_vec))
        else $error("more than one cell matched the key");

    // an accepted insert grows the set by exactly one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (update_fire && do_insert) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add one key");

    // a refused insert only happens on a full set and a missing key
    a_refuse_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_full_refused) |->
            (!m_was_present && (m_key_count == sks_pkg::OUT_COUNT_W'(CAP_CNT))))
        else $error("refused insert on a set that is not full");

    // a new result only comes out of the update step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == sks_pkg::ST_UPDATE))
        else $error("result appeared outside the update step");
`endif

endmodule

FILE: bench/tb.sv
// self-checking bench for sorted_key_set: drives insert, delete and lookup items
// with random idling on both channels and checks every result against a software copy of the set
// depends on sks_pkg and the sorted_key_set rtl
module tb;

    import sks_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int HALF_CLK   = 6;
    localparam int RANDOM_OPS = 1650;
    localparam int POOL_N     = 96;
    localparam int LONG_HOLD  = 240;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 12;

    // lookup codes: only the bench names them
    localparam logic [FUNC_W-1:0] FUNC_MEMBER = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

    typedef enum int {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED
    } phase_t;

    typedef struct {
        bit                     was_present;
        bit                     full_refused;
        bit [OUT_COUNT_W-1:0]   key_count;
    } set_result_t;

    // software copy of the set plus the queue of results still owed by the block
    class key_set_board;
        logic signed [KEY_W-1:0] keys [CAPACITY];
        int unsigned             n_keys;
        set_result_t             owed [$];
        int                      errors;
        int                      n_insert, n_delete, n_lookup, n_refused, peak;

        function new();
            n_keys = 0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_op(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] k);
            int unsigned slot;
            int unsigned i;
            bit          hit;
            set_result_t r;
            slot = 0;
            while (slot < n_keys && keys[slot] < k)
                slot++;
            hit = (slot < n_keys) && (keys[slot] == k);
            r.was_present  = hit;
            r.full_refused = 1'b0;
            if (f == FUNC_INSERT) begin
                n_insert++;
                if (!hit) begin
                    if (n_keys >= CAPACITY) begin
                        r.full_refused = 1'b1;
                        n_refused++;
                    end else begin
                        for (i = n_keys; i > slot; i--)
                            keys[i] = keys[i-1];
                        keys[slot] = k;
                        n_keys++;
                    end
                end
            end else if (f == FUNC_DELETE) begin
                n_delete++;
                if (hit) begin
                    for (i = slot; i + 1 < n_keys; i++)
                        keys[i] = keys[i+1];
                    n_keys--;
                end
            end else begin
                n_lookup++;
            end
            if (n_keys > peak)
                peak = n_keys;
            r.key_count = n_keys[OUT_COUNT_W-1:0];
            owed.push_back(r);
        endfunction

        task check_result(bit was, bit refused, bit [OUT_COUNT_W-1:0] cnt);
            set_result_t e;
            if (owed.size() == 0) begin
                report("result arrived with nothing owed");
                return;
            end
            e = owed.pop_front();
            if (was != e.was_present)
                report($sformatf("was_present got %0d want %0d", was, e.was_present));
            if (refused != e.full_refused)
                report($sformatf("full_refused got %0d want %0d", refused, e.full_refused));
            if (cnt != e.key_count)
                report($sformatf("key_count got %0d want %0d", cnt, e.key_count));
        endtask
    endclass

    // clock, reset and block ports; the ones the bench drives are known from time zero
    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [FUNC_W-1:0]             s_func         = '0;
    logic signed [KEY_W-1:0]       s_key          = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic                          m_was_present;
    logic                          m_full_refused;
    logic [OUT_COUNT_W-1:0]        m_key_count;

    key_set_board            board = new();
    logic signed [KEY_W-1:0] key_pool [POOL_N];
    bit                      quiet      = 1'b0;   // no idling on either side while set
    int                      hold_asks  = 0;      // bumped by the stimulus to ask for a long hold
    int                      hold_taken = 0;
    int                      stall_left = 0;
    int                      idle_cycles = 0;
    int                      n_results  = 0;

    always #HALF_CLK aclk = ~aclk;

    sorted_key_set #(.CAPACITY(CAPACITY)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_was_present  (m_was_present),
        .m_full_refused (m_full_refused),
        .m_key_count    (m_key_count)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // keys mostly from a shared pool so hits, duplicates and a full set are common
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return key_pool[$urandom_range(0, POOL_N-1)];
        if (r < 95) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            default: return 32'shffff_ffff;
        endcase
    endfunction

    // operation mix follows the phase: grow fills the set, shrink empties it
    function automatic logic [FUNC_W-1:0] pick_op(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95) return FUNC_SPARE;
        case (ph)
            PHASE_GROW:   return (r < 65) ? FUNC_INSERT : (r < 80) ? FUNC_DELETE : FUNC_MEMBER;
            PHASE_SHRINK: return (r < 15) ? FUNC_INSERT : (r < 80) ? FUNC_DELETE : FUNC_MEMBER;
            default:      return (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_DELETE : FUNC_MEMBER;
        endcase
    endfunction

    // offer one item, idling first if the gap says so, and note it once taken
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_key   <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_op(f, k);
    endtask

    // result side: check each taken item, then pick m_ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.check_result(m_was_present, m_full_refused, m_key_count);
                n_results++;
            end
            if (hold_asks != hold_taken) begin
                // long hold so the block backs up and stalls its input
                hold_taken = hold_asks;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: too long with no item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("** sorted_key_set: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int     n_sent;
        int     phase_len;
        int     phase_no;
        int     i;
        phase_t ph;

        // key pool: corner values first, then a mix of small and wide keys
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = 32'shffff_ffff;
        key_pool[4] = 32'sh0000_0001;
        key_pool[5] = 32'sh8000_0001;
        key_pool[6] = 32'sh7fff_fffe;
        key_pool[7] = 32'shffff_fffe;
        for (i = 8; i < POOL_N; i++)
            key_pool[i] = (i % 2) ? $signed($urandom_range(0, 200)) - 100 : $signed($urandom);

        // reset held low first, then released ahead of one spare edge
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty set, extremes, duplicates, spare code, ends and middle
        send_item(FUNC_MEMBER, 32'sh0000_0000);   // lookup on empty set
        send_item(FUNC_DELETE, 32'sh0000_0005);   // delete of absent key on empty set
        send_item(FUNC_INSERT, 32'sh0000_0000);
        send_item(FUNC_INSERT, 32'sh7fff_ffff);   // largest key
        send_item(FUNC_INSERT, 32'sh8000_0000);   // smallest key goes to the front
        send_item(FUNC_INSERT, 32'shffff_ffff);
        send_item(FUNC_INSERT, 32'sh0000_0001);
        send_item(FUNC_INSERT, 32'sh0000_0000);   // duplicate insert leaves the set alone
        send_item(FUNC_MEMBER, 32'sh7fff_ffff);
        send_item(FUNC_MEMBER, 32'sh8000_0000);
        send_item(FUNC_SPARE,  32'shffff_ffff);   // spare code acts as a lookup
        send_item(FUNC_SPARE,  32'sh0000_0002);
        send_item(FUNC_DELETE, 32'sh8000_0000);   // front entry
        send_item(FUNC_DELETE, 32'sh7fff_ffff);   // last entry
        send_item(FUNC_DELETE, 32'sh0000_0000);   // middle entry
        send_item(FUNC_DELETE, 32'sh0000_0000);   // now absent
        send_item(FUNC_INSERT, 32'sh5555_5555);
        send_item(FUNC_INSERT, 32'shaaaa_aaaa);
        send_item(FUNC_MEMBER, 32'sh5555_5555);
        send_item(FUNC_DELETE, 32'shffff_ffff);
        send_item(FUNC_DELETE, 32'sh0000_0001);
        send_item(FUNC_DELETE, 32'sh5555_5555);
        send_item(FUNC_DELETE, 32'shaaaa_aaaa);   // back to empty

        // random phases; the first two grow the set so a full set comes early
        n_sent   = 0;
        phase_no = 0;
        while (n_sent < RANDOM_OPS) begin
            if (phase_no < 2)
                ph = PHASE_GROW;
            else
                ph = phase_t'($urandom_range(0, 2));
            phase_len = $urandom_range(60, 160);
            // the long receiver hold phase also runs without sender gaps
            quiet <= (phase_no == 3) || ($urandom_range(0, 3) == 0);
            if (phase_no == 3) begin
                // block fills up behind a long receiver hold
                hold_asks <= hold_asks + 1;
            end
            for (i = 0; i < phase_len && n_sent < RANDOM_OPS; i++) begin
                send_item(pick_op(ph), pick_key());
                n_sent++;
            end
            phase_no++;
        end
        s_valid <= 1'b0;

        // drain, then keep running a little longer to catch anything stray
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("run: %0d inserts, %0d deletes, %0d lookups, %0d results checked",
                 board.n_insert, board.n_delete, board.n_lookup, n_results);
        $display("run: %0d inserts refused on a full set, peak fill %0d of %0d",
                 board.n_refused, board.peak, CAPACITY);
        if (board.errors == 0) begin
            $display("** sorted_key_set: PASSED **");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("** sorted_key_set: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sks_pkg.sv
design/sks_cell.sv
design/sorted_key_set.sv
bench/tb.sv
